// ===== design/edh_pkg.sv =====
// Package for the event first-seen filter.
// Holds the operation codes, controller states and controller/datapath structs.
// No dependencies.
`default_nettype none
package edh_pkg;

    localparam int PID_W   = 22;
    localparam int EV_W    = 2;
    localparam int DEV_W   = 32;
    localparam int INO_W   = 64;
    localparam int META_W  = 1 + PID_W + EV_W + DEV_W;
    localparam int COUNT_W = 11;
    localparam int HASH_W  = 32;
    localparam int EV_SHIFT = 24;
    localparam logic [HASH_W-1:0] HASH_MULT = 32'h61C8_8647;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_MARK   = 2'd0,
        OP_UNMARK = 2'd1,
        OP_RM_PID = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CMP,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;   // take a new beat, capture operands
        logic mul;        // register the hash product
        logic rd_bucket;  // read the bucket row
        logic key_done;   // write back bucket row, load result
        logic init_wr;    // zero one row during the reset sweep
        logic rd_walk;    // read the row under the sweep counter
        logic wr_walk;    // purge matches in that row and count them
        logic cnt_inc;    // advance the sweep counter
        logic walk_done;  // load the purge count as result
    } cmd_t;

    typedef struct packed {
        op_t  in_op;      // operation on the input channel
        logic cnt_last;   // sweep counter at the last row
        logic out_full;   // result register still holds a beat
    } status_t;

endpackage
`default_nettype wire

// ===== design/edh_req_if.sv =====
// Request channel of the event first-seen filter.
// Depends on edh_pkg for field widths.
`default_nettype none
interface edh_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [edh_pkg::PID_W-1:0]   process_id;
    logic [edh_pkg::EV_W-1:0]    event_kind;
    logic [edh_pkg::DEV_W-1:0]   device_number;
    logic [edh_pkg::INO_W-1:0]   inode_number;
    logic                        key_valid;

    modport source (output valid, operation, process_id, event_kind, device_number,
                    inode_number, key_valid, input ready);
    modport sink (input valid, operation, process_id, event_kind, device_number,
                  inode_number, key_valid, output ready);
endinterface
`default_nettype wire

// ===== design/edh_rsp_if.sv =====
// Result channel of the event first-seen filter.
// Depends on edh_pkg for field widths.
`default_nettype none
interface edh_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         is_new;
    logic                         stored;
    logic [edh_pkg::COUNT_W-1:0]  removed_count;

    modport source (output valid, is_new, stored, removed_count, input ready);
    modport sink (input valid, is_new, stored, removed_count, output ready);
endinterface
`default_nettype wire

// ===== design/edh_ctrl.sv =====
// Controller state machine of the event first-seen filter.
// Depends on edh_pkg; drives the datapath through cmd_t, watches status_t.
`default_nettype none
module edh_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire edh_pkg::status_t status,
    output edh_pkg::cmd_t         cmd
);

    edh_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edh_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edh_pkg::ST_INIT:
            begin
                if (status.cnt_last)
                begin
                    state_next = edh_pkg::ST_IDLE;
                end
            end
            edh_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (status.in_op == edh_pkg::OP_MARK || status.in_op == edh_pkg::OP_UNMARK)
                    begin
                        state_next = edh_pkg::ST_HASH;
                    end
                    else
                    begin
                        state_next = edh_pkg::ST_WALK_RD;
                    end
                end
            end
            edh_pkg::ST_HASH:    state_next = edh_pkg::ST_READ;
            edh_pkg::ST_READ:    state_next = edh_pkg::ST_CMP;
            edh_pkg::ST_CMP:
            begin
                if (!status.out_full)
                begin
                    state_next = edh_pkg::ST_IDLE;
                end
            end
            edh_pkg::ST_WALK_RD: state_next = edh_pkg::ST_WALK_WR;
            edh_pkg::ST_WALK_WR:
            begin
                state_next = status.cnt_last ? edh_pkg::ST_DONE : edh_pkg::ST_WALK_RD;
            end
            edh_pkg::ST_DONE:
            begin
                if (!status.out_full)
                begin
                    state_next = edh_pkg::ST_IDLE;
                end
            end
            default:             state_next = edh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            edh_pkg::ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            edh_pkg::ST_IDLE:    cmd.in_ready = 1'b1;
            edh_pkg::ST_HASH:    cmd.mul = 1'b1;
            edh_pkg::ST_READ:    cmd.rd_bucket = 1'b1;
            edh_pkg::ST_CMP:     cmd.key_done = !status.out_full;
            edh_pkg::ST_WALK_RD: cmd.rd_walk = 1'b1;
            edh_pkg::ST_WALK_WR:
            begin
                cmd.wr_walk = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            edh_pkg::ST_DONE:    cmd.walk_done = !status.out_full;
            default:             cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/edh_datapath.sv =====
// Datapath of the event first-seen filter: operand registers, bucket hash,
// bucket-row table memories, way compare, purge sweep and result register.
// Depends on edh_pkg and the edh_req_if / edh_rsp_if channels.
`default_nettype none
module edh_datapath #(
    parameter int BUCKET_BITS = 8,
    parameter int WAYS        = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    edh_req_if.sink              req,
    edh_rsp_if.source            rsp,
    input  wire edh_pkg::cmd_t   cmd,
    output edh_pkg::status_t     status
);

    localparam int ROWS   = 1 << BUCKET_BITS;
    localparam int MROW_W = WAYS * edh_pkg::META_W;
    localparam int IROW_W = WAYS * edh_pkg::INO_W;
    localparam int POP_W  = $clog2(WAYS + 1);
    localparam int SUM_W  = edh_pkg::COUNT_W + 1;

    // operand registers
    edh_pkg::op_t                op_reg;
    logic [edh_pkg::PID_W-1:0]   pid_reg;
    logic [edh_pkg::EV_W-1:0]    ev_reg;
    logic [edh_pkg::DEV_W-1:0]   dev_reg;
    logic [edh_pkg::INO_W-1:0]   ino_reg;
    logic                        kv_reg;
    logic [edh_pkg::HASH_W-1:0]  prod_reg;
    logic [BUCKET_BITS-1:0]      cnt_reg;
    logic [edh_pkg::COUNT_W-1:0] removed_reg, removed_next;

    logic [MROW_W-1:0] meta_mem [ROWS];
    logic [IROW_W-1:0] ino_mem  [ROWS];
    logic [MROW_W-1:0] rd_meta_reg;
    logic [IROW_W-1:0] rd_ino_reg;

    logic [edh_pkg::HASH_W-1:0]  hash;
    logic [edh_pkg::HASH_W-1:0]  prod_full;
    logic [BUCKET_BITS-1:0]      bucket;
    logic [BUCKET_BITS-1:0]      rd_addr, wr_addr;
    logic                        rd_en;
    logic                        meta_we, ino_we;
    logic [MROW_W-1:0]           wr_meta;
    logic [IROW_W-1:0]           wr_ino;
    logic [edh_pkg::META_W-1:0]  key_meta;

    logic [MROW_W-1:0]           key_meta_row, walk_meta_row;
    logic [IROW_W-1:0]           key_ino_row;
    logic                        hit, any_free, do_store, do_unmark;
    logic [POP_W-1:0]            pop;
    logic [SUM_W-1:0]            sum;

    logic                        out_valid_reg;
    logic                        out_first_reg, out_stored_reg;
    logic [edh_pkg::COUNT_W-1:0] out_count_reg;

    assign status.in_op    = edh_pkg::op_t'(req.operation);
    assign status.cnt_last = (cnt_reg == {BUCKET_BITS{1'b1}});
    assign status.out_full = out_valid_reg;
    assign req.ready       = cmd.in_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.in_ready && req.valid)
        begin
            op_reg  <= edh_pkg::op_t'(req.operation);
            pid_reg <= req.process_id;
            ev_reg  <= req.event_kind;
            dev_reg <= req.device_number;
            ino_reg <= req.inode_number;
            kv_reg  <= req.key_valid;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full;
        end
    end

    // XOR-fold then multiplicative hash; bucket is the top bits of the low product word
    assign hash = dev_reg ^ ino_reg[31:0] ^ ino_reg[63:32]
                ^ ({{(edh_pkg::HASH_W-edh_pkg::EV_W){1'b0}}, ev_reg} << edh_pkg::EV_SHIFT)
                ^ {{(edh_pkg::HASH_W-edh_pkg::PID_W){1'b0}}, pid_reg};
    assign prod_full = hash * edh_pkg::HASH_MULT;
    assign bucket    = prod_reg[edh_pkg::HASH_W-1 -: BUCKET_BITS];
    assign key_meta  = {dev_reg, ev_reg, pid_reg, 1'b1};

    // sweep counter, shared by the reset clear and the purge walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            removed_reg <= '0;
        end
        else
        begin
            if (cmd.in_ready)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            removed_reg <= removed_next;
        end
    end

    // way compare for mark / unmark
    always_comb
    begin
        hit          = 1'b0;
        any_free     = 1'b0;
        key_meta_row = rd_meta_reg;
        key_ino_row  = rd_ino_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_meta_reg[w*edh_pkg::META_W +: edh_pkg::META_W] == key_meta
                && rd_ino_reg[w*edh_pkg::INO_W +: edh_pkg::INO_W] == ino_reg)
            begin
                hit = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (op_reg == edh_pkg::OP_UNMARK
                && rd_meta_reg[w*edh_pkg::META_W +: edh_pkg::META_W] == key_meta
                && rd_ino_reg[w*edh_pkg::INO_W +: edh_pkg::INO_W] == ino_reg)
            begin
                key_meta_row[w*edh_pkg::META_W +: edh_pkg::META_W] = '0;
            end
            // lowest free way takes the new key
            if (op_reg == edh_pkg::OP_MARK && !rd_meta_reg[w*edh_pkg::META_W] && !any_free)
            begin
                any_free = 1'b1;
                key_meta_row[w*edh_pkg::META_W +: edh_pkg::META_W] = key_meta;
                key_ino_row[w*edh_pkg::INO_W +: edh_pkg::INO_W]    = ino_reg;
            end
        end
        if (op_reg == edh_pkg::OP_UNMARK)
        begin
            key_ino_row = rd_ino_reg;
        end
    end

    assign do_store  = (op_reg == edh_pkg::OP_MARK) && kv_reg && !hit && any_free;
    assign do_unmark = (op_reg == edh_pkg::OP_UNMARK) && kv_reg && hit;

    // purge one row: clear all, or the ways owned by the process
    always_comb
    begin
        walk_meta_row = rd_meta_reg;
        pop           = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_meta_reg[w*edh_pkg::META_W]
                && (op_reg == edh_pkg::OP_CLEAR
                    || rd_meta_reg[w*edh_pkg::META_W+1 +: edh_pkg::PID_W] == pid_reg))
            begin
                walk_meta_row[w*edh_pkg::META_W +: edh_pkg::META_W] = '0;
                pop = pop + 1'b1;
            end
        end
    end

    assign sum = {1'b0, removed_reg} + SUM_W'(pop);

    always_comb
    begin
        removed_next = removed_reg;
        if (cmd.in_ready)
        begin
            removed_next = '0;
        end
        else if (cmd.wr_walk)
        begin
            removed_next = sum[edh_pkg::COUNT_W] ? edh_pkg::COUNT_MAX
                                                 : sum[edh_pkg::COUNT_W-1:0];
        end
    end

    // memory ports
    assign rd_en   = cmd.rd_bucket || cmd.rd_walk;
    assign rd_addr = cmd.rd_bucket ? bucket : cnt_reg;
    assign wr_addr = cmd.key_done ? bucket : cnt_reg;
    assign meta_we = cmd.init_wr || cmd.wr_walk || (cmd.key_done && (do_store || do_unmark));
    assign ino_we  = cmd.key_done && do_store;
    assign wr_meta = cmd.init_wr ? '0 : (cmd.wr_walk ? walk_meta_row : key_meta_row);
    assign wr_ino  = key_ino_row;

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[wr_addr] <= wr_meta;
        end
        if (ino_we)
        begin
            ino_mem[wr_addr] <= wr_ino;
        end
        if (rd_en)
        begin
            rd_meta_reg <= meta_mem[rd_addr];
            rd_ino_reg  <= ino_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.key_done || cmd.walk_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_done)
        begin
            out_first_reg  <= (op_reg == edh_pkg::OP_MARK) && (!kv_reg || !hit);
            out_stored_reg <= do_store;
            out_count_reg  <= {{(edh_pkg::COUNT_W-1){1'b0}}, do_unmark};
        end
        else if (cmd.walk_done)
        begin
            out_first_reg  <= 1'b0;
            out_stored_reg <= 1'b0;
            out_count_reg  <= removed_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.is_new        = out_first_reg;
    assign rsp.stored        = out_stored_reg;
    assign rsp.removed_count = out_count_reg;

endmodule
`default_nettype wire

// ===== design/event_dedup_hash_table.sv =====
// Event first-seen filter: a set-associative table of (pid, event, device, inode) keys.
// req carries one operation per beat: mark, unmark, remove process or clear all.
// rsp returns exactly one beat per request: is_new, stored and removed_count.
// Mark and unmark pass through hash multiply, bucket row read, then compare
// and write-back (states HASH, READ, CMP), each step registered, and the
// block returns to idle for the next beat as the result is loaded.
// Remove process and clear sweep every bucket row, reading it and then
// writing it back purged (states WALK_RD, WALK_WR).
// One item is in flight at a time; req.ready is high only while idle.
// After reset a clearing pass zeroes one row a cycle, all 2^BUCKET_BITS rows
// (256 at the default size), and req.ready stays low until it ends.
// The result sits in an output register; while rsp is stalled the block
// finishes its work but holds the result, and for mark and unmark the row
// write-back, until the register frees, and meanwhile accepts nothing new.
// Depends on edh_pkg, edh_req_if, edh_rsp_if, edh_ctrl and edh_datapath.
`default_nettype none
module event_dedup_hash_table #(
    parameter int BUCKET_BITS = 8,
    parameter int WAYS        = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    edh_req_if.sink    req,
    edh_rsp_if.source  rsp
);

    edh_pkg::cmd_t    cmd;
    edh_pkg::status_t status;

    edh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .status    (status),
        .cmd       (cmd)
    );

    edh_datapath #(
        .BUCKET_BITS (BUCKET_BITS),
        .WAYS        (WAYS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the event first-seen filter: drives request beats, predicts each
// result with a behavioral copy of the hash table, and checks result beats.
// Depends on edh_pkg, edh_req_if, edh_rsp_if and event_dedup_hash_table.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BKT_BITS = 8;
    localparam int NWAYS    = 4;
    localparam int NBKT     = 1 << BKT_BITS;
    localparam int TBL_DEPTH = NBKT * NWAYS;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic                         is_new;
        logic                         stored;
        logic [edh_pkg::COUNT_W-1:0]  removed_count;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    edh_req_if req();
    edh_rsp_if rsp();

    event_dedup_hash_table #(.BUCKET_BITS(BKT_BITS), .WAYS(NWAYS)) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #4 clk = ~clk;

    // shadow table
    logic [edh_pkg::META_W-1:0] shadow_meta [TBL_DEPTH];
    logic [edh_pkg::INO_W-1:0]  shadow_ino  [TBL_DEPTH];
    verdict_t          pending_verdicts[$];
    int                n_errors = 0;
    int                idle_cycles = 0;
    int                rsp_stall_mode = 1;  // 0 never stall, 1 random
    int                stall_left = 0;

    // small pools so marks and unmarks hit keys already in the table
    logic [edh_pkg::PID_W-1:0] pid_pool [8];
    logic [edh_pkg::DEV_W-1:0] dev_pool [4];
    logic [edh_pkg::INO_W-1:0] ino_pool [16];

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic logic [BKT_BITS-1:0] bucket_hash(
        logic [edh_pkg::PID_W-1:0] pid, logic [1:0] ev, logic [edh_pkg::DEV_W-1:0] dev,
        logic [edh_pkg::INO_W-1:0] ino);
        logic [31:0] h;
        logic [31:0] p;
        h = dev ^ ino[31:0] ^ ino[63:32] ^ (32'(ev) << 24) ^ 32'(pid);
        p = h * edh_pkg::HASH_MULT;
        return p[31 -: BKT_BITS];
    endfunction

    function automatic verdict_t apply_filter(
        edh_pkg::op_t op, logic [edh_pkg::PID_W-1:0] pid, logic [1:0] ev,
        logic [edh_pkg::DEV_W-1:0] dev, logic [edh_pkg::INO_W-1:0] ino, logic kv);
        verdict_t v;
        int base;
        int hit;
        logic [edh_pkg::META_W-1:0] key_meta;
        v = '0;
        hit = -1;
        key_meta = {dev, ev, pid, 1'b1};
        base = int'(bucket_hash(pid, ev, dev, ino)) * NWAYS;
        if (op == edh_pkg::OP_MARK || op == edh_pkg::OP_UNMARK)
        begin
            if (!kv)
            begin
                v.is_new = (op == edh_pkg::OP_MARK);
            end
            else
            begin
                for (int w = 0; w < NWAYS; w++)
                    if (hit < 0 && shadow_meta[base+w] == key_meta && shadow_ino[base+w] == ino)
                        hit = base + w;
                if (op == edh_pkg::OP_MARK)
                begin
                    if (hit < 0)
                    begin
                        v.is_new = 1'b1;
                        for (int w = 0; w < NWAYS; w++)
                            if (!v.stored && !shadow_meta[base+w][0])
                            begin
                                shadow_meta[base+w] = key_meta;
                                shadow_ino[base+w] = ino;
                                v.stored = 1'b1;
                            end
                    end
                end
                else if (hit >= 0)
                begin
                    shadow_meta[hit] = '0;
                    v.removed_count = 1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
                if (shadow_meta[i][0]
                    && (op == edh_pkg::OP_CLEAR || shadow_meta[i][22:1] == pid))
                begin
                    shadow_meta[i] = '0;
                    if (v.removed_count != edh_pkg::COUNT_MAX) v.removed_count++;
                end
        end
        return v;
    endfunction

    // valid drops only when a gap is actually taken
    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return;
        req.valid <= 1'b0;
        repeat (r < 93 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
    endtask

    task automatic send_beat(input edh_pkg::op_t op, input logic [edh_pkg::PID_W-1:0] pid,
                             input logic [1:0] ev, input logic [edh_pkg::DEV_W-1:0] dev,
                             input logic [edh_pkg::INO_W-1:0] ino,
                             input logic kv, input bit gaps = 1);
        if (gaps) random_gap();
        req.valid         <= 1'b1;
        req.operation     <= op;
        req.process_id    <= pid;
        req.event_kind    <= ev;
        req.device_number <= dev;
        req.inode_number  <= ino;
        req.key_valid     <= kv;
        do @(posedge clk); while (!req.ready);
        pending_verdicts.push_back(apply_filter(op, pid, ev, dev, ino, kv));
    endtask

    task automatic send_pool_key(input edh_pkg::op_t op);
        send_beat(op, pid_pool[$urandom_range(0, 7)], 2'($urandom), dev_pool[$urandom_range(0, 3)],
                  ino_pool[$urandom_range(0, 15)], $urandom_range(0, 15) != 0);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [edh_pkg::INO_W-1:0] ino;
        send_beat(edh_pkg::OP_MARK, '1, 2'd3, '1, '1, 1'b1);
        send_beat(edh_pkg::OP_MARK, '1, 2'd3, '1, '1, 1'b1);       // present key
        send_beat(edh_pkg::OP_MARK, '0, 2'd0, '0, '0, 1'b1);
        send_beat(edh_pkg::OP_MARK, 22'd5, 2'd1, 32'd7, 64'd9, 1'b0); // no inode
        send_beat(edh_pkg::OP_UNMARK, 22'd5, 2'd1, 32'd7, 64'd9, 1'b0);
        send_beat(edh_pkg::OP_UNMARK, 22'd5, 2'd1, 32'd7, 64'd9, 1'b1); // absent
        send_beat(edh_pkg::OP_UNMARK, '1, 2'd3, '1, '1, 1'b1);
        send_beat(edh_pkg::OP_UNMARK, '1, 2'd3, '1, '1, 1'b1);
        // same pid/ev/dev, inode differing only in both halves equally: same bucket
        for (int k = 0; k < NWAYS + 2; k++)
        begin
            ino = {32'(k), 32'(k)};
            send_beat(edh_pkg::OP_MARK, 22'h2AAAAA, 2'd2, 32'h5555_5555, ino, 1'b1);
        end
        send_beat(edh_pkg::OP_UNMARK, 22'h2AAAAA, 2'd2, 32'h5555_5555, {32'd1, 32'd1}, 1'b1);
        send_beat(edh_pkg::OP_MARK, 22'h2AAAAA, 2'd2, 32'h5555_5555, {32'd9, 32'd9}, 1'b1);
        send_beat(edh_pkg::OP_RM_PID, 22'h2AAAAA, 2'd0, 32'd0, 64'd0, 1'b0);
        send_beat(edh_pkg::OP_RM_PID, 22'h2AAAAA, 2'd3, '1, '1, 1'b1);
        send_beat(edh_pkg::OP_MARK, '0, 2'd0, '0, '0, 1'b1);
        send_beat(edh_pkg::OP_CLEAR, '1, 2'd3, '1, '1, 1'b1);
        send_beat(edh_pkg::OP_CLEAR, '0, 2'd0, '0, '0, 1'b0);
        wait_drained();
    endtask

    // back-to-back marks fill much of the table, then one clear counts them
    task automatic test_fill();
        rsp_stall_mode = 0;
        for (int k = 0; k < 8; k++)
            for (int j = 0; j < 40; j++)
                send_beat(edh_pkg::OP_MARK, 22'($urandom), 2'($urandom), $urandom,
                          {$urandom, $urandom}, 1'b1, 0);
        rsp_stall_mode = 1;
        send_beat(edh_pkg::OP_CLEAR, '0, 2'd0, '0, '0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random();
        int r;
        for (int n = 0; n < 800; n++)
        begin
            r = $urandom_range(0, 199);
            if (r < 110) send_pool_key(edh_pkg::OP_MARK);
            else if (r < 180) send_pool_key(edh_pkg::OP_UNMARK);
            else if (r < 192) send_beat(edh_pkg::OP_RM_PID, pid_pool[$urandom_range(0, 7)],
                                        2'($urandom), $urandom, {$urandom, $urandom},
                                        1'($urandom));
            else if (r < 195) send_beat(edh_pkg::OP_CLEAR, 22'($urandom), 2'($urandom), $urandom,
                                        {$urandom, $urandom}, 1'($urandom));
            else send_beat(edh_pkg::op_t'($urandom_range(0, 1)), 22'($urandom), 2'($urandom),
                           $urandom, {$urandom, $urandom}, 1'($urandom));
        end
    endtask

    // result checker and result-side stalls
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rsp.valid && rsp.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (rsp.is_new !== exp_v.is_new)
                    report_mismatch($sformatf("is_new %b exp %b", rsp.is_new, exp_v.is_new));
                if (rsp.stored !== exp_v.stored)
                    report_mismatch($sformatf("stored %b exp %b", rsp.stored, exp_v.stored));
                if (rsp.removed_count !== exp_v.removed_count)
                    report_mismatch($sformatf("removed_count %0d exp %0d", rsp.removed_count,
                                              exp_v.removed_count));
            end
        end
        if (rst_n)
        begin
            if (rsp_stall_mode == 0)
            begin
                rsp.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                rsp.ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                rsp.ready  <= 1'b0;
                stall_left <= $urandom_range(8, 40);
            end
            else
            begin
                rsp.ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // watchdog on beats
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.operation = edh_pkg::OP_MARK;
        req.process_id = '0;
        req.event_kind = '0;
        req.device_number = '0;
        req.inode_number = '0;
        req.key_valid = 1'b0;
        rsp.ready = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            shadow_meta[i] = '0;
            shadow_ino[i] = '0;
        end
        for (int i = 0; i < 8; i++) pid_pool[i] = 22'($urandom);
        for (int i = 0; i < 4; i++) dev_pool[i] = $urandom;
        for (int i = 0; i < 16; i++) ino_pool[i] = {$urandom, $urandom};
        pid_pool[0] = '1;
        dev_pool[0] = '0;
        ino_pool[0] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill();
        test_random();
        wait_drained();
        if (n_errors == 0 && pending_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/edh_pkg.sv
design/edh_req_if.sv
design/edh_rsp_if.sv
design/edh_ctrl.sv
design/edh_datapath.sv
design/event_dedup_hash_table.sv
dv/tb_top.sv
